/* hw/rtl/utxp_pkg.sv */
// Package: shared types and constants for the parity UART transmitter.
package utxp_pkg;

  localparam int unsigned FifoDepth = 64;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [PeriodW-1:0] BitPeriodRst = 16'd104;

  localparam logic [ModeW-1:0] ParNone = 2'd0;
  localparam logic [ModeW-1:0] ParOdd  = 2'd1;
  localparam logic [ModeW-1:0] ParEven = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBitPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgParity    = 1'b1;

  typedef enum logic {
    ActTick  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhData   = 2'd1,
    PhParity = 2'd2,
    PhStop   = 2'd3
  } phase_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic            tx_line;
    logic            busy_res;
    logic [CntW-1:0] fifo_level;
    logic            overflow;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [7:0]      head;
  } fifo_stat_t;

  typedef struct packed {
    logic tx_line;
    logic busy;
  } frame_stat_t;

endpackage

/* hw/rtl/utxp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module utxp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/utxp_fifo.sv */
// Transmit byte FIFO: pointers, fill count, RAM and write-to-head forwarding.
module utxp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          wdata_i,
  input  logic                pop_i,
  output utxp_pkg::fifo_stat_t stat_o
);

  logic [utxp_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [utxp_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [utxp_pkg::CntW-1:0] count_q, count_d;
  logic                      fwd_valid_q, fwd_valid_d;
  logic [7:0]                fwd_data_q;
  logic [7:0]                ram_rdata;

  function automatic logic [utxp_pkg::PtrW-1:0] next_slot(logic [utxp_pkg::PtrW-1:0] p);
    logic [utxp_pkg::PtrW-1:0] r;
    if (p == utxp_pkg::PtrW'(utxp_pkg::FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d    = push_i ? next_slot(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d    = pop_i  ? next_slot(rd_ptr_q) : rd_ptr_q;
    count_d     = count_q + utxp_pkg::CntW'(push_i) - utxp_pkg::CntW'(pop_i);
    // the RAM read misses a write landing on the entry it reads this edge
    fwd_valid_d = push_i && (wr_ptr_q == rd_ptr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata_i;
  end

  utxp_ram #(
    .Width (8),
    .Depth (utxp_pkg::FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata_i),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  assign stat_o.count = count_q;
  assign stat_o.head  = fwd_valid_q ? fwd_data_q : ram_rdata;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= utxp_pkg::CntW'(utxp_pkg::FifoDepth))
    else $error("fifo count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0) && !push_i)
    else $error("pop from empty fifo or pop with push");

endmodule

/* hw/rtl/utxp_frame.sv */
// Frame sequencer: bit-period divider, start/data/parity/stop shifting.
module utxp_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          write_i,
  input  logic [utxp_pkg::PeriodW-1:0]  bit_period_i,
  input  logic [utxp_pkg::ModeW-1:0]    parity_mode_i,
  input  utxp_pkg::fifo_stat_t          fifo_i,
  output logic                          pop_o,
  output utxp_pkg::frame_stat_t         stat_o
);

  utxp_pkg::phase_e           phase_q, phase_d;
  logic [7:0]                 shift_q, shift_d;
  logic                       par_q, par_d;
  logic [2:0]                 idx_q, idx_d;
  logic [utxp_pkg::PeriodW-1:0] div_q, div_d;
  logic                       line_q, line_d;
  logic                       run_q, run_d;
  logic                       bit_end;
  logic                       fifo_empty;

  assign fifo_empty = (fifo_i.count == '0);
  assign bit_end    = ({1'b0, div_q} + 1'b1) >= {1'b0, bit_period_i};

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    par_d   = par_q;
    idx_d   = idx_q;
    div_d   = div_q;
    line_d  = line_q;
    run_d   = run_q;
    pop_o   = 1'b0;
    if (write_i) begin
      run_d = 1'b1;
    end else if (tick_i && run_q) begin
      if (!bit_end) begin
        div_d = div_q + 1'b1;
      end else begin
        div_d = '0;
        unique case (phase_q)
          utxp_pkg::PhStart: begin
            if (fifo_empty) begin
              line_d = 1'b1;
              run_d  = 1'b0;
            end else begin
              pop_o   = 1'b1;
              line_d  = 1'b0;
              shift_d = fifo_i.head;
              par_d   = (parity_mode_i == utxp_pkg::ParEven) ? ^fifo_i.head
                                                             : ~^fifo_i.head;
              idx_d   = '0;
              phase_d = utxp_pkg::PhData;
            end
          end
          utxp_pkg::PhData: begin
            line_d  = shift_q[0];
            shift_d = {1'b0, shift_q[7:1]};
            idx_d   = idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              phase_d = (parity_mode_i != utxp_pkg::ParNone) ? utxp_pkg::PhParity
                                                             : utxp_pkg::PhStop;
            end
          end
          utxp_pkg::PhParity: begin
            line_d  = par_q;
            phase_d = utxp_pkg::PhStop;
          end
          utxp_pkg::PhStop: begin
            line_d  = 1'b1;
            idx_d   = '0;
            phase_d = utxp_pkg::PhStart;
            if (fifo_empty) begin
              run_d = 1'b0;
            end
          end
          default: phase_d = utxp_pkg::PhStart;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= utxp_pkg::PhStart;
      idx_q   <= '0;
      div_q   <= '0;
      line_q  <= 1'b1;
      run_q   <= 1'b0;
      par_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      div_q   <= div_d;
      line_q  <= line_d;
      run_q   <= run_d;
      par_q   <= par_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign stat_o.tx_line = line_d;
  assign stat_o.busy    = run_d;

  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> line_q)
    else $error("line low while idle");

  a_frame_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != utxp_pkg::PhStart) |-> run_q)
    else $error("frame in flight while not running");

  a_div_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && run_q && !bit_end) |=> (div_q == $past(div_q) + 1'b1))
    else $error("divider did not advance");

endmodule

/* hw/rtl/uart_transmitter_with_parity.sv */
// Top level: UART transmitter with parity, byte FIFO and result skid buffer.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------
//  in      | in  | in_valid_i / in_stall_o | in_item_i  (action, wdata)
//  out     | out | out_valid_o / out_stall_i | out_item_o (tx_line, busy_res,
//          |     |                         |   fifo_level, overflow)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; its result is registered.
// FIFO head read from RAM is prefetched at the next read pointer, with forwarding
// of a write to the entry being read. No clearing pass: ready straight after reset.
// A two-entry output buffer lets input flow while a result waits; in_stall_o
// rises only once both entries are full.
module uart_transmitter_with_parity (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  utxp_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output utxp_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utxp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [utxp_pkg::PeriodW-1:0]  cfg_data_i
);

  logic [utxp_pkg::PeriodW-1:0] period_q;
  logic [utxp_pkg::ModeW-1:0]   mode_q;
  logic                         in_acc;
  logic                         is_write;
  logic                         full;
  logic                         push;
  logic                         pop;
  logic                         ovf;
  utxp_pkg::fifo_stat_t         fifo_stat;
  utxp_pkg::frame_stat_t        frame_stat;
  utxp_pkg::out_item_t          res;
  logic                         out_valid_q, skid_valid_q;
  utxp_pkg::out_item_t          out_q, skid_q;
  logic                         out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= utxp_pkg::BitPeriodRst;
      mode_q   <= utxp_pkg::ParNone;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        utxp_pkg::CfgBitPeriod: period_q <= cfg_data_i;
        utxp_pkg::CfgParity:    mode_q   <= cfg_data_i[utxp_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign is_write   = in_acc && (in_item_i.action == utxp_pkg::ActWrite);
  assign full       = (fifo_stat.count == utxp_pkg::CntW'(utxp_pkg::FifoDepth));
  assign push       = is_write && !full;
  assign ovf        = is_write && full;

  utxp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item_i.wdata),
    .pop_i   (pop),
    .stat_o  (fifo_stat)
  );

  utxp_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (in_acc && (in_item_i.action == utxp_pkg::ActTick)),
    .write_i       (is_write),
    .bit_period_i  (period_q),
    .parity_mode_i (mode_q),
    .fifo_i        (fifo_stat),
    .pop_o         (pop),
    .stat_o        (frame_stat)
  );

  always_comb begin
    res.tx_line    = frame_stat.tx_line;
    res.busy_res   = frame_stat.busy;
    res.fifo_level = fifo_stat.count + utxp_pkg::CntW'(push) - utxp_pkg::CntW'(pop);
    res.overflow   = ovf;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (!skid_valid_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

endmodule
